// File: sv/psm_pkg.sv
// Package for the parameter smoother: register indexes, coefficient constants
// and the configuration struct shared by the top level and the update core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package psm_pkg;

   // Configuration register indexes.
   localparam int unsigned CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_LINEAR_MODE = 2'd0,
      CSR_RAMP_STEP   = 2'd1,
      CSR_POLE_COEF   = 2'd2,
      CSR_START_VALUE = 2'd3
   } csr_index_type;

   localparam int unsigned STEP_BITS = 16;
   localparam int unsigned COEF_BITS = 17;
   localparam int unsigned COEF_FRAC = 16;

   // Unity in unsigned Q.16.
   localparam logic [COEF_BITS-1:0] COEF_ONE = 17'h10000;

   localparam logic [STEP_BITS-1:0] RAMP_STEP_RESET = 16'd1;

   typedef struct packed {
      logic                 linear_mode;
      logic [STEP_BITS-1:0] ramp_step;
      logic [COEF_BITS-1:0] pole_coef;
   } cfg_type;

endpackage

`default_nettype wire

// File: sv/psm_core.sv
// Combinational update of the held value for one target item.
// Depends on psm_pkg for the configuration struct and coefficient constants.
`timescale 1ns / 1ps
`default_nettype none

module psm_core #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire psm_pkg::cfg_type         cfg,
   input  wire logic signed [SAMPLE_BITS-1:0] target,
   input  wire logic signed [SAMPLE_BITS-1:0] held,
   output logic signed [SAMPLE_BITS-1:0]      result
);

   localparam int unsigned DW   = SAMPLE_BITS + 1;
   localparam int unsigned LCW  = (DW > psm_pkg::STEP_BITS) ? DW : psm_pkg::STEP_BITS;
   localparam int unsigned ECW  = ((DW + 1) > psm_pkg::COEF_BITS) ?
                                  (DW + 1) : psm_pkg::COEF_BITS;
   localparam int unsigned PW   = DW + psm_pkg::COEF_BITS + 1;
   localparam int unsigned SW   = PW - psm_pkg::COEF_FRAC;

   logic signed [DW-1:0]              diff;
   logic [DW-1:0]                     mag;
   logic [psm_pkg::COEF_BITS-1:0]     coef_a;
   logic [psm_pkg::COEF_BITS-1:0]     coef_b;
   logic [LCW-1:0]                    mag_l;
   logic [LCW-1:0]                    step_l;
   logic [ECW-1:0]                    twice_mag;
   logic [ECW-1:0]                    coef_b_e;
   logic signed [PW-1:0]              prod;
   logic signed [SW-1:0]              delta;
   logic signed [SW-1:0]              exp_sum;
   logic signed [SAMPLE_BITS-1:0]     step_s;
   logic signed [SAMPLE_BITS-1:0]     lin_val;
   logic signed [SAMPLE_BITS-1:0]     exp_val;

   always_comb begin
      diff = $signed({target[SAMPLE_BITS-1], target}) - $signed({held[SAMPLE_BITS-1], held});
      mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
   end

   // Linear ramp: a distance no larger than the step lands on the target,
   // otherwise the step itself fits inside the sample width.
   always_comb begin
      mag_l   = LCW'(mag);
      step_l  = LCW'(cfg.ramp_step);
      step_s  = SAMPLE_BITS'(cfg.ramp_step);
      if (mag_l <= step_l) begin
         lin_val = target;
      end else if (diff[DW-1]) begin
         lin_val = held - step_s;
      end else begin
         lin_val = held + step_s;
      end
   end

   // One-pole: (x*b + y*a) >> 16 equals y + ((x - y)*b >> 16) exactly, so a
   // single multiplier does the work. The arithmetic shift floors.
   always_comb begin
      coef_a    = (cfg.pole_coef > psm_pkg::COEF_ONE) ? psm_pkg::COEF_ONE : cfg.pole_coef;
      coef_b    = psm_pkg::COEF_ONE - coef_a;
      twice_mag = ECW'({mag, 1'b0});
      coef_b_e  = ECW'(coef_b);
      prod      = PW'(diff) * $signed({1'b0, coef_b});
      delta     = SW'(prod >>> psm_pkg::COEF_FRAC);
      exp_sum   = SW'(held) + delta;
      if (twice_mag < coef_b_e) begin
         exp_val = target;
      end else begin
         exp_val = exp_sum[SAMPLE_BITS-1:0];
      end
   end

   always_comb begin
      if (diff == '0) begin
         result = held;
      end else if (cfg.linear_mode) begin
         result = lin_val;
      end else begin
         result = exp_val;
      end
   end

endmodule

`default_nettype wire

// File: sv/parameter_smoother.sv
// Parameter smoother top level: input register, held value, result register.
// Depends on psm_pkg and psm_core.
//
// Use: each item on the req_ channel carries one target sample (signed, Q1.15
// at the default width). The block answers every item with exactly one item on
// the rsp_ channel carrying the new smoothed value, which is also kept as the
// held value for the next item. In linear mode the held value ramps toward the
// target by ramp_step per item and never overshoots; otherwise it follows the
// one-pole update with coefficient pole_coef, snapping to the target when it
// is close enough.
// Each item passes through the input register and then the result register,
// where rsp_valid rises; a stall from the receiver can hold it in either. The
// block takes one item per cycle while rsp_stall is low; the held-value feedback
// closes combinationally through the core's single multiplier and its adders,
// which sets that rate.
// The user must write registers on the csr_ port only while the block is idle;
// the block does not enforce it. Writing start_value presets the held value.
// Reset clears the held value, sets ramp_step to one and the other registers
// to zero, and empties both pipeline registers. While the receiver stalls, the
// result stays in the output register and one more item can be taken into the
// input register before req_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module parameter_smoother #(
   parameter int unsigned SAMPLE_BITS = 16
) (
   input  wire  logic                                   clock,
   input  wire  logic                                   reset,
   input  wire  logic                                   req_valid,
   output logic                                         req_stall,
   input  wire  logic signed [SAMPLE_BITS-1:0]          req_target,
   output logic                                         rsp_valid,
   input  wire  logic                                   rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]                rsp_smoothed,
   input  wire  logic                                   csr_write,
   input  wire  logic [psm_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire  logic [((SAMPLE_BITS > psm_pkg::COEF_BITS) ?
                        SAMPLE_BITS : psm_pkg::COEF_BITS)-1:0] csr_wdata
);

   psm_pkg::cfg_type               cfg_ff;
   psm_pkg::cfg_type               cfg_in;
   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic signed [SAMPLE_BITS-1:0]  target_ff;
   logic                           out_valid_ff;
   logic                           out_valid_in;
   logic signed [SAMPLE_BITS-1:0]  out_ff;
   logic signed [SAMPLE_BITS-1:0]  held_ff;
   logic signed [SAMPLE_BITS-1:0]  held_in;
   logic signed [SAMPLE_BITS-1:0]  next_value;
   logic                           advance;
   logic                           req_take;
   logic                           held_preset;

   psm_core #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_core (
      .cfg    (cfg_ff),
      .target (target_ff),
      .held   (held_ff),
      .result (next_value)
   );

   // The input item moves on whenever the output register is empty or is
   // being emptied in this cycle.
   always_comb begin
      advance      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall    = in_valid_ff && !advance;
      req_take     = req_valid && !req_stall;
      in_valid_in  = req_take || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && rsp_stall);
      rsp_valid    = out_valid_ff;
      rsp_smoothed = out_ff;
   end

   // Register writes. An update from an item wins over a preset of the held
   // value, though the two never meet in normal use.
   always_comb begin
      cfg_in      = cfg_ff;
      held_preset = 1'b0;
      if (csr_write) begin
         case (csr_index)
            psm_pkg::CSR_LINEAR_MODE: cfg_in.linear_mode = csr_wdata[0];
            psm_pkg::CSR_RAMP_STEP:   cfg_in.ramp_step =
                                         csr_wdata[psm_pkg::STEP_BITS-1:0];
            psm_pkg::CSR_POLE_COEF:   cfg_in.pole_coef =
                                         csr_wdata[psm_pkg::COEF_BITS-1:0];
            psm_pkg::CSR_START_VALUE: held_preset = 1'b1;
            default:                  cfg_in = cfg_ff;
         endcase
      end
      if (advance) begin
         held_in = next_value;
      end else if (held_preset) begin
         held_in = csr_wdata[SAMPLE_BITS-1:0];
      end else begin
         held_in = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.linear_mode <= 1'b0;
         cfg_ff.ramp_step   <= psm_pkg::RAMP_STEP_RESET;
         cfg_ff.pole_coef   <= '0;
         held_ff            <= '0;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         held_ff      <= held_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         target_ff <= req_target;
      end
      if (advance) begin
         out_ff <= next_value;
      end
   end

   // A result entering the output register is the new held value.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff == held_ff))
      else $error("result register and held value disagree");

   // The input side only stalls when both pipeline registers are occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // A pending result leaves only by being taken.
   assert property (@(posedge clock) disable iff (reset)
      $fell(out_valid_ff) |-> $past(!rsp_stall))
      else $error("result dropped while stalled");

   // A zero ramp step in linear mode leaves the held value where it is.
   assert property (@(posedge clock) disable iff (reset)
      (advance && cfg_ff.linear_mode && (cfg_ff.ramp_step == '0)
       && (next_value != target_ff)) |=> $stable(held_ff))
      else $error("held value moved with a zero ramp step");

endmodule

`default_nettype wire
